### sv/ata_block_to_taskfile_defines.svh
// Assertion macros used by the checker of this block.
`ifndef ATA_BLOCK_TO_TASKFILE_DEFINES_SVH
`define ATA_BLOCK_TO_TASKFILE_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ATAB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define ATAB_ASSERT(label, prop, msg) \
    `ATAB_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### sv/atab_pkg.sv
`default_nettype none
package atab_pkg;

    localparam int BLOCK_W     = 28;
    localparam int COUNT_W     = 9;
    localparam int BYTE_W      = 8;
    localparam int HEAD_W      = 4;
    localparam int CYL_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = 7;
    localparam int DIV_STAGES  = BLOCK_W / DIV_STEPS;
    localparam int NSTG        = 2 * DIV_STAGES;

    localparam logic [BYTE_W-1:0] DH_BASE    = 8'hA0;
    localparam logic [BYTE_W-1:0] DH_SLAVE   = 8'h10;
    localparam logic [BYTE_W-1:0] DH_LBA     = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_PIO_RD = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_PIO_WR = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_DMA_RD = 8'hC8;
    localparam logic [BYTE_W-1:0] CMD_DMA_WR = 8'hCA;
    localparam logic [BYTE_W-1:0] DEVCTL_PIO = 8'h08;
    localparam logic [BYTE_W-1:0] DEVCTL_DMA = 8'h00;

    localparam logic [BYTE_W-1:0] SPT_RESET  = 8'd63;
    localparam logic [4:0]        HPC_RESET  = 5'd16;
    localparam logic [4:0]        HPC_MAX    = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LBA_MODE  = 3'd0,
        CFG_SPT       = 3'd1,
        CFG_HPC       = 3'd2,
        CFG_DRIVE_SEL = 3'd3,
        CFG_DMA_EN    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              lba_mode;
        logic [BYTE_W-1:0] spt;
        logic [BYTE_W-1:0] hpc;
        logic              drive_select;
        logic              dma_enable;
    } t_cfg;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [COUNT_W-1:0] sect_cnt;
        logic               write;
        logic [BYTE_W-1:0]  sector;
    } t_side;

    // dq shifts dividend out at the top and quotient bits in at the bottom
    typedef struct packed {
        logic [BLOCK_W-1:0] dq;
        logic [BYTE_W-1:0]  rem;
        t_side              side;
    } t_div;

endpackage
`default_nettype wire

### sv/atab_if.sv
`default_nettype none
interface atab_req_if;
    logic                         valid;
    logic                         ready;
    logic [atab_pkg::BLOCK_W-1:0] block;
    logic [atab_pkg::COUNT_W-1:0] sect_cnt;
    logic                         write;

    modport source (output valid, block, sect_cnt, write, input ready);
    modport sink   (input valid, block, sect_cnt, write, output ready);
endinterface

interface atab_tf_if;
    logic                        valid;
    logic                        ready;
    logic [atab_pkg::BYTE_W-1:0] sector_number;
    logic [atab_pkg::BYTE_W-1:0] cylinder_low;
    logic [atab_pkg::BYTE_W-1:0] cylinder_high;
    logic [atab_pkg::BYTE_W-1:0] device_head;
    logic [atab_pkg::BYTE_W-1:0] count_byte;
    logic [atab_pkg::BYTE_W-1:0] command_code;
    logic [atab_pkg::BYTE_W-1:0] device_control;

    modport source (output valid, sector_number, cylinder_low, cylinder_high, device_head,
                    count_byte, command_code, device_control, input ready);
    modport sink   (input valid, sector_number, cylinder_low, cylinder_high, device_head,
                    count_byte, command_code, device_control, output ready);
endinterface

interface atab_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [atab_pkg::CFG_IDX_W-1:0] index;
    logic [atab_pkg::BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ata_block_to_taskfile.sv
// Pipeline: an accepted request reaches the task-file outputs through
//   9 register stages: 4 dividing by sectors per track, 4 by heads, 1 output.
// Throughput: one request per cycle; the whole pipe holds while the output waits.
// Reset: synchronous active low; clears all valid bits and loads the register
//   defaults (CHS, 63 sectors, 16 heads, master, PIO).
`default_nettype none
module ata_block_to_taskfile (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    atab_req_if.sink  i_req,
    atab_cfg_if.sink  i_cfg,
    atab_tf_if.source o_tf
);

    atab_pkg::t_cfg w_cfg;
    logic           w_en;
    logic           w_vin  [atab_pkg::NSTG];
    atab_pkg::t_div w_din  [atab_pkg::NSTG];
    logic           w_vout [atab_pkg::NSTG];
    atab_pkg::t_div w_dout [atab_pkg::NSTG];

    atab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign i_req.ready = w_en;

    always_comb begin
        w_vin[0]                     = i_req.valid;
        w_din[0].dq                  = i_req.block;
        w_din[0].rem                 = '0;
        w_din[0].side.block          = i_req.block;
        w_din[0].side.sect_cnt       = i_req.sect_cnt;
        w_din[0].side.write          = i_req.write;
        w_din[0].side.sector         = '0;
    end

    genvar s;
    generate
        for (s = 1; s < atab_pkg::NSTG; s++) begin : g_link
            if (s == atab_pkg::DIV_STAGES) begin : g_reload
                // quotient becomes the next dividend, remainder + 1 is the sector
                always_comb begin
                    w_vin[s]             = w_vout[s-1];
                    w_din[s].dq          = w_dout[s-1].dq;
                    w_din[s].rem         = '0;
                    w_din[s].side        = w_dout[s-1].side;
                    w_din[s].side.sector = w_dout[s-1].rem + 8'd1;
                end
            end else begin : g_pass
                assign w_vin[s] = w_vout[s-1];
                assign w_din[s] = w_dout[s-1];
            end
        end

        for (s = 0; s < atab_pkg::NSTG; s++) begin : g_stage
            atab_div_stage u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_en      (w_en),
                .i_valid   (w_vin[s]),
                .i_d       (w_din[s]),
                .i_divisor ((s < atab_pkg::DIV_STAGES) ? w_cfg.spt : w_cfg.hpc),
                .o_valid   (w_vout[s]),
                .o_d       (w_dout[s])
            );
        end
    endgenerate

    atab_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vout[atab_pkg::NSTG-1]),
        .i_d     (w_dout[atab_pkg::NSTG-1]),
        .i_cfg   (w_cfg),
        .o_en    (w_en),
        .o_tf    (o_tf)
    );

endmodule
`default_nettype wire

### sv/atab_cfg.sv
`default_nettype none
module atab_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    atab_cfg_if.sink       i_cfg,
    output atab_pkg::t_cfg o_cfg
);

    logic                          r_lba_mode;
    logic [atab_pkg::BYTE_W-1:0]   r_spt;
    logic [4:0]                    r_hpc;
    logic                          r_drive_select;
    logic                          r_dma_enable;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba_mode     <= 1'b0;
            r_spt          <= atab_pkg::SPT_RESET;
            r_hpc          <= atab_pkg::HPC_RESET;
            r_drive_select <= 1'b0;
            r_dma_enable   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                atab_pkg::CFG_LBA_MODE:  r_lba_mode     <= i_cfg.data[0];
                atab_pkg::CFG_SPT:       r_spt          <= i_cfg.data;
                atab_pkg::CFG_HPC:       r_hpc          <= i_cfg.data[4:0];
                atab_pkg::CFG_DRIVE_SEL: r_drive_select <= i_cfg.data[0];
                atab_pkg::CFG_DMA_EN:    r_dma_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // zero geometry counts as one, heads clamp at sixteen
    always_comb begin
        o_cfg.lba_mode     = r_lba_mode;
        o_cfg.spt          = (r_spt == '0) ? 8'd1 : r_spt;
        priority if (r_hpc == '0) begin
            o_cfg.hpc = 8'd1;
        end else if (r_hpc > atab_pkg::HPC_MAX) begin
            o_cfg.hpc = {3'b000, atab_pkg::HPC_MAX};
        end else begin
            o_cfg.hpc = {3'b000, r_hpc};
        end
        o_cfg.drive_select = r_drive_select;
        o_cfg.dma_enable   = r_dma_enable;
    end

endmodule
`default_nettype wire

### sv/atab_div_stage.sv
`default_nettype none
module atab_div_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire atab_pkg::t_div              i_d,
    input  wire logic [atab_pkg::BYTE_W-1:0] i_divisor,
    output logic                             o_valid,
    output atab_pkg::t_div                   o_d
);

    logic           r_valid;
    atab_pkg::t_div r_d;
    atab_pkg::t_div n_d;

    // restoring division, DIV_STEPS quotient bits per stage
    always_comb begin
        logic [atab_pkg::BYTE_W:0] v_rem;
        logic                      v_bit;
        n_d = i_d;
        for (int k = 0; k < atab_pkg::DIV_STEPS; k++) begin
            v_rem = {n_d.rem, n_d.dq[atab_pkg::BLOCK_W-1]};
            v_bit = (v_rem >= {1'b0, i_divisor});
            if (v_bit) begin
                v_rem = v_rem - {1'b0, i_divisor};
            end
            n_d.rem = v_rem[atab_pkg::BYTE_W-1:0];
            n_d.dq  = {n_d.dq[atab_pkg::BLOCK_W-2:0], v_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule
`default_nettype wire

### sv/atab_fmt.sv
`default_nettype none
module atab_fmt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire atab_pkg::t_div i_d,
    input  wire atab_pkg::t_cfg i_cfg,
    output logic                o_en,
    atab_tf_if.source           o_tf
);

    logic                        r_valid;
    logic [atab_pkg::BYTE_W-1:0] r_sect;
    logic [atab_pkg::BYTE_W-1:0] r_cyl_lo;
    logic [atab_pkg::BYTE_W-1:0] r_cyl_hi;
    logic [atab_pkg::BYTE_W-1:0] r_dh;
    logic [atab_pkg::BYTE_W-1:0] r_cnt;
    logic [atab_pkg::BYTE_W-1:0] r_cmd;
    logic [atab_pkg::BYTE_W-1:0] r_ctl;

    logic [atab_pkg::BYTE_W-1:0] n_sect;
    logic [atab_pkg::CYL_W-1:0]  n_cyl;
    logic [atab_pkg::HEAD_W-1:0] n_head;
    logic [atab_pkg::BYTE_W-1:0] n_dh;
    logic [atab_pkg::BYTE_W-1:0] n_cmd;
    logic [atab_pkg::BYTE_W-1:0] n_ctl;

    assign o_en = !r_valid || o_tf.ready;

    always_comb begin
        if (i_cfg.lba_mode) begin
            n_sect = i_d.side.block[7:0];
            n_cyl  = i_d.side.block[23:8];
            n_head = i_d.side.block[27:24];
        end else begin
            n_sect = i_d.side.sector;
            n_cyl  = i_d.dq[atab_pkg::CYL_W-1:0];
            n_head = i_d.rem[atab_pkg::HEAD_W-1:0];
        end
        n_dh = atab_pkg::DH_BASE
             | (i_cfg.drive_select ? atab_pkg::DH_SLAVE : '0)
             | (i_cfg.lba_mode ? atab_pkg::DH_LBA : '0)
             | {4'b0000, n_head};
        if (i_cfg.dma_enable) begin
            n_cmd = i_d.side.write ? atab_pkg::CMD_DMA_WR : atab_pkg::CMD_DMA_RD;
            n_ctl = atab_pkg::DEVCTL_DMA;
        end else begin
            n_cmd = i_d.side.write ? atab_pkg::CMD_PIO_WR : atab_pkg::CMD_PIO_RD;
            n_ctl = atab_pkg::DEVCTL_PIO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_sect   <= n_sect;
            r_cyl_lo <= n_cyl[7:0];
            r_cyl_hi <= n_cyl[15:8];
            r_dh     <= n_dh;
            r_cnt    <= i_d.side.sect_cnt[atab_pkg::BYTE_W-1:0];
            r_cmd    <= n_cmd;
            r_ctl    <= n_ctl;
        end
    end

    assign o_tf.valid          = r_valid;
    assign o_tf.sector_number  = r_sect;
    assign o_tf.cylinder_low   = r_cyl_lo;
    assign o_tf.cylinder_high  = r_cyl_hi;
    assign o_tf.device_head    = r_dh;
    assign o_tf.count_byte     = r_cnt;
    assign o_tf.command_code   = r_cmd;
    assign o_tf.device_control = r_ctl;

endmodule
`default_nettype wire

### sv/atab_checker.sv
`default_nettype none
`include "ata_block_to_taskfile_defines.svh"
module atab_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_tf_valid,
    input wire logic                        i_tf_ready,
    input wire logic [atab_pkg::BYTE_W-1:0] i_tf_device_head,
    input wire logic [atab_pkg::BYTE_W-1:0] i_tf_command_code,
    input wire logic [atab_pkg::BYTE_W-1:0] i_tf_device_control
);

    logic w_wait;
    logic w_dh_fixed;
    logic w_pio_cmd;
    logic w_pio_ctl;

    assign w_wait     = i_tf_valid && !i_tf_ready;
    assign w_dh_fixed = i_tf_device_head[7] && i_tf_device_head[5];
    assign w_pio_cmd  = (i_tf_command_code == atab_pkg::CMD_PIO_RD)
                     || (i_tf_command_code == atab_pkg::CMD_PIO_WR);
    assign w_pio_ctl  = (i_tf_device_control == atab_pkg::DEVCTL_PIO);

    `ATAB_ASSERT(a_tf_hold, (w_wait |=> i_tf_valid), "result dropped while stalled")
    `ATAB_ASSERT(a_tf_stable, (w_wait |=> $stable(i_tf_command_code)), "result changed")
    `ATAB_ASSERT(a_dh_fixed, (i_tf_valid |-> w_dh_fixed), "device/head fixed bits missing")
    `ATAB_ASSERT(a_ctl_cmd, (i_tf_valid |-> (w_pio_ctl == w_pio_cmd)), "control vs command")

endmodule

bind ata_block_to_taskfile atab_checker u_atab_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_tf_valid          (o_tf.valid),
    .i_tf_ready          (o_tf.ready),
    .i_tf_device_head    (o_tf.device_head),
    .i_tf_command_code   (o_tf.command_code),
    .i_tf_device_control (o_tf.device_control)
);
`default_nettype wire

### tb/sv/tb_ata_block_to_taskfile.sv
`timescale 1ns / 100ps
module tb_ata_block_to_taskfile;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 8;
    localparam int          DRAIN_TAIL    = 12;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          RAND_PHASES   = 14;
    localparam int          PHASE_ITEMS   = 100;
    localparam logic [2:0]  CFG_SPARE_LO  = 3'd5;
    localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [atab_pkg::BYTE_W-1:0] sector_number;
        logic [atab_pkg::BYTE_W-1:0] cylinder_low;
        logic [atab_pkg::BYTE_W-1:0] cylinder_high;
        logic [atab_pkg::BYTE_W-1:0] device_head;
        logic [atab_pkg::BYTE_W-1:0] count_byte;
        logic [atab_pkg::BYTE_W-1:0] command_code;
        logic [atab_pkg::BYTE_W-1:0] device_control;
    } t_taskfile;

    typedef struct packed {
        atab_pkg::t_cfg               cfg;
        logic [atab_pkg::BLOCK_W-1:0] blk;
        logic [atab_pkg::COUNT_W-1:0] cnt;
        logic                         wr;
        logic                         typed;
        t_taskfile                    tf;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    atab_req_if req_if ();
    atab_cfg_if cfg_if ();
    atab_tf_if  tf_if ();

    ata_block_to_taskfile uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_tf    (tf_if)
    );

    // register copy as the block holds it
    logic                        geo_lba;
    logic [atab_pkg::BYTE_W-1:0] geo_spt;
    logic [4:0]                  geo_hpc;
    logic                        geo_slave;
    logic                        geo_dma;

    t_taskfile      taskfile_q [$];
    t_row           dir_rows [$];
    atab_pkg::t_cfg cur_cfg;

    logic      row_typed;
    t_taskfile row_tf;

    bit        burst_mode;
    int        err_count;
    int        req_count;
    int        tf_count;
    int        cfg_count;
    int        stall_cycles;
    bit        moved;
    t_taskfile got_tf;
    t_taskfile want_tf;

    string tf_field [7] = '{"sector_number", "cylinder_low", "cylinder_high",
                            "device_head", "count_byte", "command_code", "device_control"};

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic int unsigned spt_eff();
        return (geo_spt == 0) ? 1 : int'(geo_spt);
    endfunction

    function automatic int unsigned hpc_eff();
        if (geo_hpc == 0)
            return 1;
        return (geo_hpc > atab_pkg::HPC_MAX) ? int'(atab_pkg::HPC_MAX) : int'(geo_hpc);
    endfunction

    function automatic t_taskfile compute_taskfile(logic [atab_pkg::BLOCK_W-1:0] blk,
                                                   logic [atab_pkg::COUNT_W-1:0] cnt,
                                                   logic wr);
        int unsigned sect;
        int unsigned cyl;
        int unsigned head;
        int unsigned q;
        t_taskfile   tf;
        if (geo_lba) begin
            sect = blk[7:0];
            cyl  = blk[23:8];
            head = blk[27:24];
        end else begin
            sect = (blk % spt_eff()) + 1;
            q    = blk / spt_eff();
            head = q % hpc_eff();
            cyl  = q / hpc_eff();
        end
        tf.sector_number  = sect[7:0];
        tf.cylinder_low   = cyl[7:0];
        tf.cylinder_high  = cyl[15:8];
        tf.device_head    = atab_pkg::DH_BASE | (geo_slave ? atab_pkg::DH_SLAVE : 8'h00) |
                            (geo_lba ? atab_pkg::DH_LBA : 8'h00) | {4'h0, head[3:0]};
        tf.count_byte     = cnt[7:0];
        if (geo_dma) begin
            tf.command_code   = wr ? atab_pkg::CMD_DMA_WR : atab_pkg::CMD_DMA_RD;
            tf.device_control = atab_pkg::DEVCTL_DMA;
        end else begin
            tf.command_code   = wr ? atab_pkg::CMD_PIO_WR : atab_pkg::CMD_PIO_RD;
            tf.device_control = atab_pkg::DEVCTL_PIO;
        end
        return tf;
    endfunction

    function automatic atab_pkg::t_cfg make_cfg(logic lba, logic [7:0] spt, logic [7:0] hpc,
                                                logic slave, logic dma);
        atab_pkg::t_cfg s;
        s.lba_mode     = lba;
        s.spt          = spt;
        s.hpc          = hpc;
        s.drive_select = slave;
        s.dma_enable   = dma;
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_row(atab_pkg::t_cfg s, logic [atab_pkg::BLOCK_W-1:0] blk,
                           logic [atab_pkg::COUNT_W-1:0] cnt,
                           logic wr, logic typed, t_taskfile tf);
        t_row row;
        row.cfg   = s;
        row.blk   = blk;
        row.cnt   = cnt;
        row.wr    = wr;
        row.typed = typed;
        row.tf    = tf;
        dir_rows.push_back(row);
    endtask

    task automatic cfg_write(logic [atab_pkg::CFG_IDX_W-1:0] idx,
                             logic [atab_pkg::BYTE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        unique case (idx)
            atab_pkg::CFG_LBA_MODE:  geo_lba   = val[0];
            atab_pkg::CFG_SPT:       geo_spt   = val;
            atab_pkg::CFG_HPC:       geo_hpc   = val[4:0];
            atab_pkg::CFG_DRIVE_SEL: geo_slave = val[0];
            atab_pkg::CFG_DMA_EN:    geo_dma   = val[0];
            default: ;
        endcase
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (taskfile_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // upper data bits of the 1-bit registers are random
    task automatic apply_settings(atab_pkg::t_cfg s);
        drain_requests();
        cfg_write(atab_pkg::CFG_LBA_MODE, {7'($urandom), s.lba_mode});
        cfg_write(atab_pkg::CFG_SPT, s.spt);
        cfg_write(atab_pkg::CFG_HPC, s.hpc);
        cfg_write(atab_pkg::CFG_DRIVE_SEL, {7'($urandom), s.drive_select});
        if ($urandom_range(0, 2) == 0)
            cfg_write(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
        cfg_write(atab_pkg::CFG_DMA_EN, {7'($urandom), s.dma_enable});
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        cur_cfg = s;
        cfg_count++;
    endtask

    task automatic push_request(logic [atab_pkg::BLOCK_W-1:0] blk,
                                logic [atab_pkg::COUNT_W-1:0] cnt, logic wr,
                                logic typed, t_taskfile tf);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.block    <= blk;
        req_if.sect_cnt <= cnt;
        req_if.write    <= wr;
        row_typed       <= typed;
        row_tf          <= tf;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    function automatic logic [atab_pkg::BLOCK_W-1:0] random_block();
        int          r;
        int unsigned cyc;
        r   = $urandom_range(0, 9);
        cyc = geo_lba ? 256 : spt_eff() * hpc_eff();
        if (r < 4)
            return atab_pkg::BLOCK_W'($urandom);
        if (r < 6)
            return atab_pkg::BLOCK_W'($urandom_range(0, 4095));
        if (r < 9)
            return atab_pkg::BLOCK_W'($urandom_range(0, 65800) * cyc
                                      + $urandom_range(0, 2) - 1);
        return ~atab_pkg::BLOCK_W'($urandom_range(0, 255));
    endfunction

    function automatic atab_pkg::t_cfg random_settings();
        int         r;
        logic [7:0] spt;
        logic [7:0] hpc;
        r = $urandom_range(0, 9);
        unique case (r)
            0:       spt = 8'd0;
            1:       spt = 8'd1;
            2:       spt = 8'd255;
            default: spt = 8'($urandom);
        endcase
        r = $urandom_range(0, 9);
        unique case (r)
            0:       hpc = 8'd0;
            1:       hpc = 8'd1;
            2:       hpc = 8'd16;
            3:       hpc = 8'd17;
            4:       hpc = 8'd31;
            5:       hpc = 8'($urandom_range(1, 16));
            default: hpc = 8'($urandom);
        endcase
        return make_cfg(1'($urandom), spt, hpc, 1'($urandom), 1'($urandom));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                req_count++;
                if (row_typed)
                    taskfile_q.push_back(row_tf);
                else
                    taskfile_q.push_back(compute_taskfile(req_if.block, req_if.sect_cnt,
                                                          req_if.write));
            end
            if (cfg_if.valid && cfg_if.ready)
                moved = 1'b1;
            if (tf_if.valid && tf_if.ready) begin
                moved = 1'b1;
                got_tf = {tf_if.sector_number, tf_if.cylinder_low, tf_if.cylinder_high,
                          tf_if.device_head, tf_if.count_byte, tf_if.command_code,
                          tf_if.device_control};
                if (taskfile_q.size() == 0) begin
                    report_mismatch($sformatf("task-file result with no request pending: %h",
                                              got_tf));
                end else begin
                    want_tf = taskfile_q.pop_front();
                    tf_count++;
                    for (int k = 0; k < 7; k++) begin
                        if (got_tf[55-8*k -: 8] !== want_tf[55-8*k -: 8])
                            report_mismatch($sformatf("result %0d %s got %h want %h",
                                tf_count, tf_field[k], got_tf[55-8*k -: 8],
                                want_tf[55-8*k -: 8]));
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, taskfile_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int gap;
        forever begin
            tf_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                tf_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        atab_pkg::t_cfg rst_cfg;
        atab_pkg::t_cfg lba_cfg;
        atab_pkg::t_cfg fast_cfg;
        atab_pkg::t_cfg zero_cfg;
        atab_pkg::t_cfg wide_cfg;
        atab_pkg::t_cfg wrap_cfg;
        atab_pkg::t_cfg odd_cfg;
        atab_pkg::t_cfg full_cfg;

        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.block    <= '0;
        req_if.sect_cnt <= '0;
        req_if.write    <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        row_typed       <= 1'b0;
        row_tf          <= '0;
        burst_mode   = 1'b0;
        err_count    = 0;
        req_count    = 0;
        tf_count     = 0;
        cfg_count    = 0;
        stall_cycles = 0;
        geo_lba      = 1'b0;
        geo_spt      = atab_pkg::SPT_RESET;
        geo_hpc      = atab_pkg::HPC_RESET;
        geo_slave    = 1'b0;
        geo_dma      = 1'b0;

        rst_cfg  = make_cfg(1'b0, atab_pkg::SPT_RESET, {3'b000, atab_pkg::HPC_RESET},
                            1'b0, 1'b0);
        lba_cfg  = make_cfg(1'b1, 8'd63, 8'd16, 1'b0, 1'b0);
        fast_cfg = make_cfg(1'b1, 8'd63, 8'd16, 1'b1, 1'b1);
        zero_cfg = make_cfg(1'b0, 8'd0, 8'd0, 1'b1, 1'b1);
        wide_cfg = make_cfg(1'b0, 8'd255, 8'd31, 1'b0, 1'b0);
        wrap_cfg = make_cfg(1'b0, 8'd1, 8'hE0, 1'b0, 1'b1);
        odd_cfg  = make_cfg(1'b0, 8'd7, 8'd17, 1'b1, 1'b0);
        full_cfg = make_cfg(1'b0, 8'hFF, 8'hFF, 1'b0, 1'b1);
        cur_cfg  = rst_cfg;

        // reset geometry, CHS
        add_row(rst_cfg, 28'd0, 9'd1, 1'b0, 1'b1, 56'h01_00_00_A0_01_20_08);
        add_row(rst_cfg, 28'd62, 9'd256, 1'b1, 1'b1, 56'h3F_00_00_A0_00_30_08);
        add_row(rst_cfg, 28'd63, 9'd2, 1'b0, 1'b1, 56'h01_00_00_A1_02_20_08);
        add_row(rst_cfg, 28'd1007, 9'd255, 1'b0, 1'b1, 56'h3F_00_00_AF_FF_20_08);
        add_row(rst_cfg, 28'd1008, 9'd0, 1'b1, 1'b1, 56'h01_01_00_A0_00_30_08);
        add_row(rst_cfg, 28'hFFFFFFF, 9'd257, 1'b0, 1'b1, 56'h10_41_10_A0_01_20_08);
        add_row(rst_cfg, 28'd66060288, 9'd1, 1'b0, 1'b1, 56'h01_00_00_A0_01_20_08);
        // LBA split
        add_row(lba_cfg, 28'hFFFFFFF, 9'd256, 1'b0, 1'b1, 56'hFF_FF_FF_EF_00_20_08);
        add_row(lba_cfg, 28'h0123456, 9'd511, 1'b1, 1'b1, 56'h56_34_12_E0_FF_30_08);
        add_row(lba_cfg, 28'h5A5A5A5, 9'd170, 1'b0, 1'b1, 56'hA5_A5_A5_E5_AA_20_08);
        // LBA, slave, DMA
        add_row(fast_cfg, 28'hA5A5A5A, 9'h155, 1'b1, 1'b1, 56'h5A_5A_5A_FA_55_CA_00);
        add_row(fast_cfg, 28'd0, 9'd1, 1'b0, 1'b1, 56'h00_00_00_F0_01_C8_00);
        // zero geometry treated as one
        add_row(zero_cfg, 28'hFFFFFFF, 9'd1, 1'b0, 1'b1, 56'h01_FF_FF_B0_01_C8_00);
        add_row(zero_cfg, 28'd12345, 9'd99, 1'b1, 1'b0, '0);
        // head count above 16 saturates
        add_row(wide_cfg, 28'd254, 9'd2, 1'b1, 1'b1, 56'hFF_00_00_A0_02_30_08);
        add_row(wide_cfg, 28'd4079, 9'd3, 1'b0, 1'b1, 56'hFF_00_00_AF_03_20_08);
        add_row(wide_cfg, 28'h7654321, 9'd300, 1'b1, 1'b0, '0);
        // head data above 5 bits dropped, cylinder wraps
        add_row(wrap_cfg, 28'h0ABCDEF, 9'd100, 1'b1, 1'b1, 56'h01_EF_CD_A0_64_CA_00);
        add_row(wrap_cfg, 28'h0FFFF00, 9'd8, 1'b0, 1'b0, '0);
        add_row(odd_cfg, 28'd999999, 9'd37, 1'b1, 1'b0, '0);
        add_row(odd_cfg, 28'hFFFFFFE, 9'd511, 1'b0, 1'b0, '0);
        add_row(full_cfg, 28'h8000000, 9'd128, 1'b0, 1'b0, '0);
        add_row(full_cfg, 28'h1FFFFFF, 9'd256, 1'b1, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg != cur_cfg)
                apply_settings(dir_rows[r].cfg);
            push_request(dir_rows[r].blk, dir_rows[r].cnt, dir_rows[r].wr,
                         dir_rows[r].typed, dir_rows[r].tf);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_settings(random_settings());
            burst_mode = (p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_request(random_block(),
                             ($urandom_range(0, 9) < 8)
                                 ? atab_pkg::COUNT_W'($urandom_range(1, 256))
                                 : atab_pkg::COUNT_W'($urandom),
                             1'($urandom), 1'b0, '0);
        end
        burst_mode = 1'b0;

        drain_requests();

        $display("covered %0d requests over %0d register settings (CHS, LBA, PIO, DMA)",
                 req_count, cfg_count);
        $display("checked %0d task-file results, %0d field errors", tf_count, err_count);
        if (err_count == 0 && taskfile_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
